/* design/polyh_pkg.sv */
// Shared widths, saturation bounds and sequencer state type for the Horner evaluator.
package polyh_pkg;

   localparam int DEG_W  = 10;
   localparam int IDX_W  = 10;
   localparam int COEF_W = 32;
   localparam int X_W    = 32;
   localparam int ACC_W  = 48;
   localparam int HALF_W = 24;                  // Q.24 fraction bits
   localparam int HI_W   = HALF_W + X_W;        // high partial product
   localparam int LO_W   = HALF_W + 1 + X_W;    // low partial product, zero-extended low half
   localparam int SUM_W  = HI_W + 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_INIT = 4'b0010,
      S_MUL  = 4'b0100,
      S_ADD  = 4'b1000
   } state_type;

endpackage

/* design/polynomial_horner_evaluator.sv */
// Horner polynomial evaluator: coefficient memory, multiply/accumulate sequencer, result strobe.
//
// Usage:
//  - Command channel: an item is taken at a clock edge with start high and busy low.
//    req_command = load writes req_coef_value into coefficient slot req_coef_index
//    (indices at or above MAX_TERMS are dropped) and gives no result; the block stays
//    ready, so loads can be issued every cycle while no evaluate is busy.
//  - req_command = evaluate starts a Horner walk from slot degree down to slot 0 at
//    x = req_x_value. busy is high for the walk. Each coefficient step uses one
//    memory read and the shared multiply/add datapath, first in a multiply state
//    (partial products registered), then in an add state (add, shift and saturate).
//  - Result channel: rsp_strobe is high for one cycle with rsp_poly_value (Q24.24,
//    saturated) and rsp_overflow (any step saturated). The receiver cannot stall;
//    a new item may be accepted in the strobe cycle.
//  - csr_wr_en/csr_wr_data write the degree register; write only while idle.
//  - Reset (synchronous) clears the sequencer, degree and accumulator. Coefficient
//    memory is not cleared; every slot up to degree must be loaded before evaluating.
module polynomial_horner_evaluator #(
   parameter int MAX_TERMS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [polyh_pkg::IDX_W-1:0]         req_coef_index,
   input  logic signed [polyh_pkg::COEF_W-1:0] req_coef_value,
   input  logic signed [polyh_pkg::X_W-1:0]    req_x_value,
   input  logic                                csr_wr_en,
   input  logic [polyh_pkg::DEG_W-1:0]         csr_wr_data,
   output logic                                rsp_strobe,
   output logic signed [polyh_pkg::ACC_W-1:0]  rsp_poly_value,
   output logic                                rsp_overflow
);
   import polyh_pkg::*;

   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int IW = (AW > IDX_W) ? AW : IDX_W;

   // coefficient store and its registered read port
   logic [COEF_W-1:0] coef_mem [MAX_TERMS];
   logic [COEF_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   // control
   state_type         state_ff, state_in;
   logic [DEG_W-1:0]  degree_ff;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              ovf_ff, ovf_in;

   // datapath
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [X_W-1:0]    x_ff;
   logic signed [HI_W-1:0]   p_hi_ff;
   logic signed [LO_W-1:0]   p_lo_ff;

   logic              accept;
   logic              accept_eval;
   logic [IW-1:0]     idx_wide;
   logic [IW-1:0]     deg_wide;
   logic [IW-1:0]     top_wide;
   logic [AW-1:0]     top_addr;
   logic signed [HALF_W-1:0] acc_hi;
   logic signed [HALF_W:0]   acc_lo;
   logic [SUM_W-1:0]  step_sum;
   logic              step_sat;
   logic [ACC_W-1:0]  step_val;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign accept_eval = accept && (req_command == CMD_EVAL);

   // load address; slots beyond the store are ignored
   assign idx_wide = IW'(req_coef_index);
   assign wr_addr  = idx_wide[AW-1:0];
   assign wr_en    = accept && (req_command == CMD_LOAD)
                     && (32'(req_coef_index) < 32'(MAX_TERMS));

   // top slot = degree clamped to the store size
   assign deg_wide = IW'(degree_ff);
   assign top_wide = (deg_wide > IW'(MAX_TERMS - 1)) ? IW'(MAX_TERMS - 1) : deg_wide;
   assign top_addr = top_wide[AW-1:0];

   // Split acc = hi*2^24 + lo so ((acc*x) >>> 24) = hi*x + ((lo*x) >>> 24) exactly.
   assign acc_hi = signed'(acc_ff[ACC_W-1:HALF_W]);
   assign acc_lo = signed'({1'b0, acc_ff[HALF_W-1:0]});

   // add step: both partial products plus the next coefficient, then saturate to 48 bits
   assign step_sum = {{(SUM_W-HI_W){p_hi_ff[HI_W-1]}}, p_hi_ff}
                   + {{(SUM_W-(LO_W-HALF_W)){p_lo_ff[LO_W-1]}}, p_lo_ff[LO_W-1:HALF_W]}
                   + {{(SUM_W-COEF_W){rd_data_ff[COEF_W-1]}}, rd_data_ff};
   assign step_sat = (step_sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b0}})
                  && (step_sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){1'b1}});
   assign step_val = !step_sat ? step_sum[ACC_W-1:0]
                   : (step_sum[SUM_W-1] ? SAT_MIN : SAT_MAX);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      rsp_strobe_in = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff - AW'(1);
      case (state_ff)
         S_IDLE: begin
            if (accept_eval) begin
               // fetch the top coefficient
               rd_en    = 1'b1;
               rd_addr  = top_addr;
               idx_in   = top_addr;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            acc_in = {{(ACC_W-COEF_W){rd_data_ff[COEF_W-1]}}, rd_data_ff};
            ovf_in = 1'b0;
            if (idx_ff == '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               idx_in   = idx_ff - AW'(1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            acc_in = step_val;
            ovf_in = ovf_ff | step_sat;
            if (idx_ff == '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               idx_in   = idx_ff - AW'(1);
               state_in = S_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         degree_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         acc_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         ovf_ff        <= ovf_in;
         acc_ff        <= acc_in;
         if (csr_wr_en) begin
            degree_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept_eval) begin
         x_ff <= req_x_value;
      end
      if (state_ff == S_MUL) begin
         p_hi_ff <= HI_W'(acc_hi) * HI_W'(x_ff);
         p_lo_ff <= LO_W'(acc_lo) * LO_W'(x_ff);
      end
   end

   // coefficient memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_addr] <= req_coef_value;
      end
      if (rd_en) begin
         rd_data_ff <= coef_mem[rd_addr];
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_poly_value = signed'(acc_ff);
   assign rsp_overflow   = ovf_ff;

`ifndef SYNTHESIS
   // a result only follows the init or add step of a walk
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == S_INIT || $past(state_ff) == S_ADD))
      else $error("result strobe without a finishing step");

   // the block is ready again when the result is shown
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy during result strobe");

   // an accepted evaluate starts with the top-coefficient fetch
   a_eval_init: assert property (@(posedge clock) disable iff (reset)
      accept_eval |=> (state_ff == S_INIT))
      else $error("evaluate did not enter init");

   // multiply is always followed by the add step
   a_mul_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |=> (state_ff == S_ADD))
      else $error("multiply not followed by add");

   // a non-final add step fetches and loops back to multiply
   a_add_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && idx_ff != '0) |=> (state_ff == S_MUL && !rsp_strobe))
      else $error("walk ended early");
`endif

endmodule
